FILE: src/i2cm_pkg.sv
//------------------------------------------------------------------------------
// I2C master transaction engine package
// Shared types, phase and role codes, operation, status and register codes,
// and the tick, result and configuration records.
//------------------------------------------------------------------------------
package i2cm_pkg;

    localparam int COUNT_BITS = 16;

    // Operation codes carried by a tick.
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_REG_WR  = 3'd3;
    localparam logic [2:0] OP_REG_RD  = 3'd4;

    // Completion status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_NO_DEV   = 3'd2;
    localparam logic [2:0] ST_REG_NAK  = 3'd3;
    localparam logic [2:0] ST_INCOMPL  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_HALF    = 2'd0;
    localparam logic [1:0] REG_STRETCH = 2'd1;
    localparam logic [1:0] REG_BUSWAIT = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_REL, PH_ST_SCL, PH_ST_WAIT, PH_ST_SDA,
        PH_BIT_SET, PH_BIT_HIGH, PH_BIT_WAIT, PH_BIT_EXTRA, PH_TX_WAIT,
        PH_SP_SDA, PH_SP_SCL, PH_SP_WAIT, PH_SP_HOLD, PH_SP_REL
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_ADDR_W, ROLE_REG, ROLE_PAY_W, ROLE_ADDR_R, ROLE_READ
    } t_role;

    // One accepted tick as the sequencer sees it.
    typedef struct packed {
        logic [2:0]            operation;
        logic [6:0]            device_address;
        logic [7:0]            register_index;
        logic [COUNT_BITS-1:0] byte_count;
        logic [7:0]            tx_byte;
        logic                  tx_valid;
        logic                  scl_in;
        logic                  sda_in;
    } t_tick;

    // One result of the sequencer.
    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       tx_request;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_last;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
    } t_result;

    // Configuration values handed to the sequencer.
    typedef struct packed {
        logic [7:0]  half_period_ticks;
        logic [15:0] stretch_limit_ticks;
        logic [15:0] bus_wait_limit_ticks;
    } t_cfg;

endpackage

FILE: src/i2cm_front.sv
//------------------------------------------------------------------------------
// I2C master front end
// Takes tick transfers from the slave stream, unpacks the fields and stores
// them in a two-entry queue for the sequencer.
//------------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [47:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_tick       o_tick
);

    t_tick      r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, n_rd;
    logic       r_wr, n_wr;
    t_tick      w_in;
    logic       w_push, w_pop;

    // Unpack a tick from its bus layout.
    always_comb begin
        w_in.operation      = i_data[2:0];
        w_in.device_address = i_data[9:3];
        w_in.register_index = i_data[17:10];
        w_in.byte_count     = i_data[33:18];
        w_in.tx_byte        = i_data[41:34];
        w_in.tx_valid       = i_data[42];
        w_in.scl_in         = i_data[43];
        w_in.sda_in         = i_data[44];
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tick  = r_q[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Queue pointers and fill count.
    always_comb begin
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        n_rd  = r_rd ^ w_pop;
        n_wr  = r_wr ^ w_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
            r_wr  <= n_wr;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_in;
        end
    end

endmodule

FILE: src/i2cm_seq.sv
//------------------------------------------------------------------------------
// I2C master sequencer
// Advances one step per queued tick: start, address, register, payload and
// read bytes with acknowledge bits, repeated start and stop. Results go to a
// two-entry output queue so that a stall on the master side does not stop
// the queue drain until it is full.
//------------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_tick       i_tick,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_res
);

    t_phase                r_phase, n_phase;
    logic [2:0]            r_mode, n_mode;
    logic [3:0]            r_bits, n_bits;
    logic [7:0]            r_shift, n_shift;
    logic [COUNT_BITS-1:0] r_left, n_left;
    logic [15:0]           r_timer, n_timer;
    logic [6:0]            r_addr, n_addr;
    logic [7:0]            r_reg, n_reg;
    logic [2:0]            r_code, n_code;
    logic                  r_scl, n_scl;
    logic                  r_sda, n_sda;
    t_role                 r_role, n_role;

    t_result    w_res;
    t_result    r_oq [2];
    logic [1:0] r_ocnt;
    logic       r_ord, r_owr;
    logic       w_step, w_pop;
    logic [7:0] w_half;
    logic       w_held;
    logic [15:0] w_tinc;
    logic       w_sample, w_nak, w_done;
    logic       w_enter_bit, w_start, w_stop;
    logic [2:0] w_stop_code;
    logic [7:0] w_begin_val;
    logic       w_begin;
    logic [3:0] w_bits_inc;
    logic [7:0] w_shift_s;

    assign o_ready = (r_ocnt != 2'd2);
    assign w_step  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_ocnt != 2'd0);
    assign o_res   = r_oq[r_ord];

    assign w_half = (i_cfg.half_period_ticks == 8'd0) ? 8'd1 : i_cfg.half_period_ticks;
    assign w_tinc = r_timer + 16'd1;
    assign w_held = (w_tinc >= {8'd0, w_half});

    // Next state of the transaction sequencer.
    always_comb begin
        n_phase = r_phase; n_mode = r_mode; n_bits = r_bits; n_shift = r_shift;
        n_left = r_left; n_timer = r_timer; n_addr = r_addr; n_reg = r_reg;
        n_code = r_code; n_scl = r_scl; n_sda = r_sda; n_role = r_role;
        w_sample = 1'b0; w_done = 1'b0; w_start = 1'b0; w_stop = 1'b0;
        w_stop_code = ST_OK; w_begin = 1'b0; w_begin_val = 8'd0;
        w_enter_bit = 1'b0; w_nak = 1'b0;
        w_res = '0;
        w_bits_inc = r_bits + 4'd1;
        w_shift_s = {r_shift[6:0], (r_role == ROLE_READ) ? i_tick.sda_in : 1'b0};

        case (r_phase)
            PH_IDLE: begin
                n_scl = 1'b0; n_sda = 1'b0;
                if (i_tick.operation >= OP_WRITE && i_tick.operation <= OP_REG_RD) begin
                    n_mode  = i_tick.operation;
                    n_addr  = i_tick.device_address;
                    n_reg   = i_tick.register_index;
                    n_left  = i_tick.byte_count;
                    if ((i_tick.operation == OP_READ || i_tick.operation == OP_REG_RD)
                        && i_tick.byte_count == '0) begin
                        n_left = {{(COUNT_BITS-1){1'b0}}, 1'b1};
                    end
                    n_code  = ST_OK;
                    n_bits  = 4'd0;
                    n_shift = 8'd0;
                    n_role  = (i_tick.operation == OP_READ) ? ROLE_ADDR_R : ROLE_ADDR_W;
                    w_start = 1'b1;
                end
            end
            PH_ST_REL: begin
                n_timer = w_tinc;
                if (w_held) begin
                    n_scl = 1'b0; n_phase = PH_ST_SCL; n_timer = '0;
                end
            end
            PH_ST_SCL: begin
                n_timer = w_tinc;
                if (w_held) begin
                    n_phase = PH_ST_WAIT; n_timer = '0;
                end
            end
            PH_ST_WAIT: begin
                if (i_tick.scl_in) begin
                    n_sda = 1'b1; n_phase = PH_ST_SDA; n_timer = '0;
                end else if (r_timer >= i_cfg.bus_wait_limit_ticks) begin
                    n_code = ST_TIMEOUT; w_done = 1'b1;
                end else begin
                    n_timer = w_tinc;
                end
            end
            PH_ST_SDA: begin
                n_timer = w_tinc;
                if (w_held) begin
                    n_scl = 1'b1;
                    w_begin = 1'b1;
                    w_begin_val = {r_addr, (r_role == ROLE_ADDR_R) ? 1'b1 : 1'b0};
                end
            end
            PH_BIT_SET: begin
                n_timer = w_tinc;
                if (w_held) begin
                    n_scl = 1'b0; n_phase = PH_BIT_HIGH; n_timer = '0;
                end
            end
            PH_BIT_HIGH: begin
                n_timer = w_tinc;
                if (w_held) begin
                    n_phase = PH_BIT_WAIT; n_timer = '0;
                end
            end
            PH_BIT_WAIT: begin
                if (i_tick.scl_in || r_timer >= i_cfg.stretch_limit_ticks) begin
                    if (r_timer == '0) begin
                        w_sample = 1'b1;
                    end else begin
                        n_phase = PH_BIT_EXTRA; n_timer = '0;
                    end
                end else begin
                    n_timer = w_tinc;
                end
            end
            PH_BIT_EXTRA: begin
                n_timer = w_tinc;
                if (w_held) begin
                    w_sample = 1'b1;
                end
            end
            PH_TX_WAIT: begin
                n_scl = 1'b1;
                if (i_tick.tx_valid) begin
                    w_begin = 1'b1; w_begin_val = i_tick.tx_byte;
                end
            end
            PH_SP_SDA: begin
                n_timer = w_tinc;
                if (w_held) begin
                    n_scl = 1'b0; n_phase = PH_SP_SCL; n_timer = '0;
                end
            end
            PH_SP_SCL: begin
                n_timer = w_tinc;
                if (w_held) begin
                    n_phase = PH_SP_WAIT; n_timer = '0;
                end
            end
            PH_SP_WAIT: begin
                if (i_tick.scl_in) begin
                    n_phase = PH_SP_HOLD; n_timer = '0;
                end else if (r_timer >= i_cfg.bus_wait_limit_ticks) begin
                    n_code = ST_TIMEOUT; n_phase = PH_SP_HOLD; n_timer = '0;
                end else begin
                    n_timer = w_tinc;
                end
            end
            PH_SP_HOLD: begin
                n_timer = w_tinc;
                if (w_held) begin
                    n_sda = 1'b0; n_phase = PH_SP_REL; n_timer = '0;
                end
            end
            PH_SP_REL: begin
                n_timer = w_tinc;
                if (w_held) begin
                    w_done = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE; n_timer = '0; n_scl = 1'b0; n_sda = 1'b0;
                n_code = ST_OK;
            end
        endcase

        // Sampling edge of a bit: shift, count, and byte completion.
        if (w_sample) begin
            if (r_bits < 4'd8) begin
                n_shift = w_shift_s;
                if (r_role == ROLE_READ && r_bits == 4'd7) begin
                    w_res.rx_valid = 1'b1;
                    w_res.rx_byte  = w_shift_s;
                    w_res.rx_last  = (r_left <= 1);
                end
            end else begin
                w_nak = i_tick.sda_in;
            end
            n_scl  = 1'b1;
            n_bits = w_bits_inc;
            if (w_bits_inc >= 4'd9) begin
                case (r_role)
                    ROLE_ADDR_W: begin
                        if (w_nak) begin
                            w_stop = 1'b1; w_stop_code = ST_NO_DEV;
                        end else if (r_mode == OP_WRITE) begin
                            n_role = ROLE_PAY_W;
                            if (r_left == '0) w_stop = 1'b1;
                            else begin n_phase = PH_TX_WAIT; n_timer = '0; end
                        end else begin
                            n_role = ROLE_REG; w_begin = 1'b1; w_begin_val = r_reg;
                        end
                    end
                    ROLE_REG: begin
                        if (w_nak) begin
                            w_stop = 1'b1; w_stop_code = ST_REG_NAK;
                        end else if (r_mode == OP_REG_WR) begin
                            n_role = ROLE_PAY_W;
                            if (r_left == '0) w_stop = 1'b1;
                            else begin n_phase = PH_TX_WAIT; n_timer = '0; end
                        end else begin
                            n_role = ROLE_ADDR_R; w_start = 1'b1;
                        end
                    end
                    ROLE_PAY_W: begin
                        if (w_nak) begin
                            w_stop = 1'b1; w_stop_code = ST_INCOMPL;
                        end else begin
                            n_left = r_left - 1'b1;
                            if (r_left == 1) w_stop = 1'b1;
                            else begin n_phase = PH_TX_WAIT; n_timer = '0; end
                        end
                    end
                    ROLE_ADDR_R: begin
                        if (w_nak) begin
                            w_stop = 1'b1; w_stop_code = ST_NO_DEV;
                        end else begin
                            n_role = ROLE_READ; w_begin = 1'b1; w_begin_val = 8'd0;
                        end
                    end
                    default: begin
                        if (r_left <= 1) begin
                            n_left = '0; w_stop = 1'b1;
                        end else begin
                            n_left = r_left - 1'b1;
                            w_begin = 1'b1; w_begin_val = 8'd0;
                        end
                    end
                endcase
            end else begin
                w_enter_bit = 1'b1;
            end
        end

        // Byte begin, start and stop entries.
        if (w_begin) begin
            n_shift = w_begin_val; n_bits = 4'd0; w_enter_bit = 1'b1;
        end
        if (w_enter_bit) begin
            if (n_bits < 4'd8) begin
                n_sda = (n_role == ROLE_READ) ? 1'b0 : ~n_shift[7];
            end else begin
                n_sda = (n_role == ROLE_READ) ? (n_left > 1) : 1'b0;
            end
            n_phase = PH_BIT_SET; n_timer = '0;
        end
        if (w_start) begin
            n_sda = 1'b0; n_phase = PH_ST_REL; n_timer = '0;
        end
        if (w_stop) begin
            if (r_code == ST_OK) n_code = w_stop_code;
            n_sda = 1'b1; n_phase = PH_SP_SDA; n_timer = '0;
        end
        if (w_done) begin
            n_phase = PH_IDLE; n_timer = '0; n_scl = 1'b0; n_sda = 1'b0;
        end

        w_res.scl_pull_low = n_scl;
        w_res.sda_pull_low = n_sda;
        w_res.tx_request   = (n_phase == PH_TX_WAIT);
        w_res.busy_res     = (n_phase != PH_IDLE);
        w_res.done_res     = w_done;
        w_res.status       = w_done ? n_code : ST_OK;
    end

    // Sequencer state; advances only on a tick transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_mode <= '0; r_bits <= '0; r_shift <= '0;
            r_left <= '0; r_timer <= '0; r_addr <= '0; r_reg <= '0;
            r_code <= '0; r_scl <= 1'b0; r_sda <= 1'b0; r_role <= ROLE_ADDR_W;
        end else if (w_step) begin
            r_phase <= n_phase; r_mode <= n_mode; r_bits <= n_bits;
            r_shift <= n_shift; r_left <= n_left; r_timer <= n_timer;
            r_addr <= n_addr; r_reg <= n_reg; r_code <= n_code;
            r_scl <= n_scl; r_sda <= n_sda; r_role <= n_role;
        end
    end

    // Result queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0; r_ord <= 1'b0; r_owr <= 1'b0;
        end else begin
            r_ocnt <= r_ocnt + {1'b0, w_step} - {1'b0, w_pop};
            r_ord  <= r_ord ^ w_pop;
            r_owr  <= r_owr ^ w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_oq[r_owr] <= w_res;
        end
    end

endmodule

FILE: src/i2c_master_transaction_engine_unit.sv
//------------------------------------------------------------------------------
// I2C master transaction engine
// Open-drain I2C master that runs whole write, read, register write and
// register read transactions, one tick transfer in, one result transfer out.
//------------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tick: command fields, payload byte, sampled lines
// m_axis    out        result: line drives, tx request, rx byte, status
// apb       in         three timing registers at byte addresses 0, 4, 8
//
// One tick is taken every clock cycle while s_axis_tready is high; each tick
// passes the tick queue, and its result the sequencer's result queue.
// Reset is synchronous and restores the idle state and register defaults.
// A stall on the master side fills the result queue, then stops the
// sequencer, then fills the tick queue, then deasserts s_axis_tready.
//------------------------------------------------------------------------------
module i2c_master_transaction_engine_unit import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation, device_address, register_index, byte_count, tx_byte,
    // tx_valid, scl_in, sda_in; zero fill to 48 bits
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_pull_low, sda_pull_low, tx_request, rx_byte, rx_valid, busy_res,
    // done_res, status; zero fill to 24 bits
    output logic [23:0] m_axis_tdata,
    // rx_last
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        r_cfg;
    t_tick       w_tick;
    t_result     w_res;
    logic        w_fv, w_fr;
    logic        w_wr;
    logic [1:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks    <= 8'd2;
            r_cfg.stretch_limit_ticks  <= 16'd1000;
            r_cfg.bus_wait_limit_ticks <= 16'd30000;
        end else if (w_wr) begin
            case (w_idx)
                REG_HALF:    r_cfg.half_period_ticks    <= pwdata[7:0];
                REG_STRETCH: r_cfg.stretch_limit_ticks  <= pwdata[15:0];
                REG_BUSWAIT: r_cfg.bus_wait_limit_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_idx)
            REG_HALF:    prdata = {24'd0, r_cfg.half_period_ticks};
            REG_STRETCH: prdata = {16'd0, r_cfg.stretch_limit_ticks};
            REG_BUSWAIT: prdata = {16'd0, r_cfg.bus_wait_limit_ticks};
            default:     prdata = 32'd0;
        endcase
    end

    i2cm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (w_fv),
        .i_ready (w_fr),
        .o_tick  (w_tick)
    );

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_tick  (w_tick),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    // Pack the result transfer.
    assign m_axis_tdata = {7'd0, w_res.status, w_res.done_res, w_res.busy_res,
                           w_res.rx_valid, w_res.rx_byte, w_res.tx_request,
                           w_res.sda_pull_low, w_res.scl_pull_low};
    assign m_axis_tlast = w_res.rx_last;

endmodule

FILE: dv/i2cm_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// I2C master transaction engine checker
// Watches the tick, result and register channels, keeps its own model of the
// transaction sequencer and compares every result transfer field by field.
//------------------------------------------------------------------------------
module i2cm_checker import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_last_busy,
    output int          o_txn_count,
    output int          o_rx_count
);

    // Shadow copy of the timing registers.
    logic [7:0]  half_ticks;
    logic [15:0] stretch_limit;
    logic [15:0] bus_wait_limit;

    // Shadow copy of the sequencer state.
    t_phase      phase_q;
    t_role       role_q;
    logic [2:0]  mode_q;
    logic [3:0]  bit_idx;
    logic [7:0]  shifter;
    logic [15:0] bytes_left;
    int unsigned tick_count;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_index;
    logic [2:0]  result_code;
    logic        drv_scl;
    logic        drv_sda;
    logic [7:0]  got_byte;
    logic        got_valid;
    logic        got_last;
    logic        ended;

    t_result expected_results[$];

    function automatic void goto_phase(t_phase p);
        phase_q    = p;
        tick_count = 0;
    endfunction

    // A held phase lasts one half period; zero counts as one.
    function automatic bit half_elapsed();
        tick_count++;
        return tick_count >= ((half_ticks == 0) ? 1 : half_ticks);
    endfunction

    function automatic void enter_bit();
        if (bit_idx < 8) begin
            drv_sda = (role_q == ROLE_READ) ? 1'b0 : !shifter[7];
        end else begin
            drv_sda = (role_q == ROLE_READ) ? (bytes_left > 1) : 1'b0;
        end
        goto_phase(PH_BIT_SET);
    endfunction

    function automatic void load_byte(logic [7:0] value);
        shifter = value;
        bit_idx = 4'd0;
        enter_bit();
    endfunction

    function automatic void start_condition();
        drv_sda = 1'b0;
        goto_phase(PH_ST_REL);
    endfunction

    // A failure code set before the stop is kept; a stop timeout still overrides it.
    function automatic void stop_condition(logic [2:0] code);
        if (result_code == ST_OK) result_code = code;
        drv_sda = 1'b1;
        goto_phase(PH_SP_SDA);
    endfunction

    function automatic void end_transaction();
        phase_q    = PH_IDLE;
        tick_count = 0;
        drv_scl    = 1'b0;
        drv_sda    = 1'b0;
        ended      = 1'b1;
    endfunction

    function automatic void payload_or_stop();
        if (bytes_left == 0) stop_condition(ST_OK);
        else goto_phase(PH_TX_WAIT);
    endfunction

    // Decide what follows a whole byte and its acknowledge bit.
    function automatic void byte_finished(logic nak);
        case (role_q)
            ROLE_ADDR_W: begin
                if (nak) stop_condition(ST_NO_DEV);
                else if (mode_q == OP_WRITE) begin
                    role_q = ROLE_PAY_W;
                    payload_or_stop();
                end else begin
                    role_q = ROLE_REG;
                    load_byte(reg_index);
                end
            end
            ROLE_REG: begin
                if (nak) stop_condition(ST_REG_NAK);
                else if (mode_q == OP_REG_WR) begin
                    role_q = ROLE_PAY_W;
                    payload_or_stop();
                end else begin
                    role_q = ROLE_ADDR_R;
                    start_condition();
                end
            end
            ROLE_PAY_W: begin
                if (nak) stop_condition(ST_INCOMPL);
                else begin
                    bytes_left = bytes_left - 16'd1;
                    payload_or_stop();
                end
            end
            ROLE_ADDR_R: begin
                if (nak) stop_condition(ST_NO_DEV);
                else begin
                    role_q = ROLE_READ;
                    load_byte(8'h00);
                end
            end
            default: begin
                if (bytes_left > 0) bytes_left = bytes_left - 16'd1;
                if (bytes_left == 0) stop_condition(ST_OK);
                else load_byte(8'h00);
            end
        endcase
    endfunction

    function automatic void sample_line(logic sda);
        logic nak;
        nak = 1'b0;
        if (bit_idx < 8) begin
            if (role_q == ROLE_READ) begin
                shifter = {shifter[6:0], sda};
                if (bit_idx == 7) begin
                    got_valid = 1'b1;
                    got_byte  = shifter;
                    got_last  = (bytes_left <= 1);
                end
            end else begin
                shifter = {shifter[6:0], 1'b0};
            end
        end else begin
            nak = sda;
        end
        drv_scl = 1'b1;
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= 9) byte_finished(nak);
        else enter_bit();
    endfunction

    // Advance the shadow sequencer by one tick and return its result.
    function automatic t_result step_engine(t_tick t);
        t_result r;
        got_byte  = 0;
        got_valid = 0;
        got_last  = 0;
        ended     = 0;
        case (phase_q)
            PH_IDLE: begin
                drv_scl = 0;
                drv_sda = 0;
                if (t.operation inside {OP_WRITE, OP_READ, OP_REG_WR, OP_REG_RD}) begin
                    mode_q      = t.operation;
                    dev_addr    = t.device_address;
                    reg_index   = t.register_index;
                    bytes_left  = t.byte_count;
                    if ((t.operation == OP_READ || t.operation == OP_REG_RD)
                        && bytes_left == 0) bytes_left = 16'd1;
                    result_code = ST_OK;
                    bit_idx     = 4'd0;
                    shifter     = 8'd0;
                    role_q      = (t.operation == OP_READ) ? ROLE_ADDR_R : ROLE_ADDR_W;
                    start_condition();
                end
            end
            PH_ST_REL: if (half_elapsed()) begin
                drv_scl = 0;
                goto_phase(PH_ST_SCL);
            end
            PH_ST_SCL: if (half_elapsed()) goto_phase(PH_ST_WAIT);
            PH_ST_WAIT: begin
                if (t.scl_in) begin
                    drv_sda = 1'b1;
                    goto_phase(PH_ST_SDA);
                end else if (tick_count >= bus_wait_limit) begin
                    result_code = ST_TIMEOUT;
                    end_transaction();
                end else tick_count++;
            end
            PH_ST_SDA: if (half_elapsed()) begin
                drv_scl = 1'b1;
                load_byte({dev_addr, role_q == ROLE_ADDR_R});
            end
            PH_BIT_SET: if (half_elapsed()) begin
                drv_scl = 0;
                goto_phase(PH_BIT_HIGH);
            end
            PH_BIT_HIGH: if (half_elapsed()) goto_phase(PH_BIT_WAIT);
            PH_BIT_WAIT: begin
                if (t.scl_in || tick_count >= stretch_limit) begin
                    if (tick_count == 0) sample_line(t.sda_in);
                    else goto_phase(PH_BIT_EXTRA);
                end else tick_count++;
            end
            PH_BIT_EXTRA: if (half_elapsed()) sample_line(t.sda_in);
            PH_TX_WAIT: begin
                drv_scl = 1'b1;
                if (t.tx_valid) load_byte(t.tx_byte);
            end
            PH_SP_SDA: if (half_elapsed()) begin
                drv_scl = 0;
                goto_phase(PH_SP_SCL);
            end
            PH_SP_SCL: if (half_elapsed()) goto_phase(PH_SP_WAIT);
            PH_SP_WAIT: begin
                if (t.scl_in) goto_phase(PH_SP_HOLD);
                else if (tick_count >= bus_wait_limit) begin
                    result_code = ST_TIMEOUT;
                    goto_phase(PH_SP_HOLD);
                end else tick_count++;
            end
            PH_SP_HOLD: if (half_elapsed()) begin
                drv_sda = 0;
                goto_phase(PH_SP_REL);
            end
            PH_SP_REL: if (half_elapsed()) end_transaction();
            default: begin
                // An unknown phase falls back to idle quietly.
                end_transaction();
                result_code = ST_OK;
                ended       = 1'b0;
            end
        endcase
        r.scl_pull_low = drv_scl;
        r.sda_pull_low = drv_sda;
        r.tx_request   = (phase_q == PH_TX_WAIT);
        r.rx_byte      = got_byte;
        r.rx_valid     = got_valid;
        r.rx_last      = got_last;
        r.busy_res     = (phase_q != PH_IDLE);
        r.done_res     = ended;
        r.status       = ended ? result_code : ST_OK;
        return r;
    endfunction

    function automatic void compare_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_last_busy  = 0;
        o_txn_count  = 0;
        o_rx_count   = 0;
    end

    always @(posedge i_clk) begin
        t_tick   tick;
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            half_ticks     = 8'd2;
            stretch_limit  = 16'd1000;
            bus_wait_limit = 16'd30000;
            phase_q        = PH_IDLE;
            role_q         = ROLE_ADDR_W;
            mode_q         = 0;
            bit_idx        = 0;
            shifter        = 0;
            bytes_left     = 0;
            tick_count     = 0;
            dev_addr       = 0;
            reg_index      = 0;
            result_code    = ST_OK;
            drv_scl        = 0;
            drv_sda        = 0;
            expected_results.delete();
        end else begin
            // Register writes update the shadow configuration.
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_HALF:    half_ticks     = pwdata[7:0];
                    REG_STRETCH: stretch_limit  = pwdata[15:0];
                    REG_BUSWAIT: bus_wait_limit = pwdata[15:0];
                    default: ;
                endcase
            end
            // Every accepted tick transfer yields exactly one expected result.
            if (s_axis_tvalid && s_axis_tready) begin
                tick.operation      = s_axis_tdata[2:0];
                tick.device_address = s_axis_tdata[9:3];
                tick.register_index = s_axis_tdata[17:10];
                tick.byte_count     = s_axis_tdata[33:18];
                tick.tx_byte        = s_axis_tdata[41:34];
                tick.tx_valid       = s_axis_tdata[42];
                tick.scl_in         = s_axis_tdata[43];
                tick.sda_in         = s_axis_tdata[44];
                expected_results.push_back(step_engine(tick));
            end
            // Compare each result transfer with the oldest expectation.
            if (m_axis_tvalid && m_axis_tready) begin
                seen.scl_pull_low = m_axis_tdata[0];
                seen.sda_pull_low = m_axis_tdata[1];
                seen.tx_request   = m_axis_tdata[2];
                seen.rx_byte      = m_axis_tdata[10:3];
                seen.rx_valid     = m_axis_tdata[11];
                seen.busy_res     = m_axis_tdata[12];
                seen.done_res     = m_axis_tdata[13];
                seen.status       = m_axis_tdata[16:14];
                seen.rx_last      = m_axis_tlast;
                o_last_busy       = seen.busy_res;
                if (seen.done_res) o_txn_count++;
                if (seen.rx_valid) o_rx_count++;
                if (expected_results.size() == 0) begin
                    $error("result transfer arrived with no expectation waiting");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("scl_pull_low", want.scl_pull_low, seen.scl_pull_low);
                    compare_field("sda_pull_low", want.sda_pull_low, seen.sda_pull_low);
                    compare_field("tx_request", want.tx_request, seen.tx_request);
                    compare_field("rx_byte", want.rx_byte, seen.rx_byte);
                    compare_field("rx_valid", want.rx_valid, seen.rx_valid);
                    compare_field("rx_last", want.rx_last, seen.rx_last);
                    compare_field("busy_res", want.busy_res, seen.busy_res);
                    compare_field("done_res", want.done_res, seen.done_res);
                    compare_field("status", want.status, seen.status);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// I2C master transaction engine testbench
// Streams pin-sample ticks with commands, payload bytes, acknowledges and
// clock stretching through the engine under several timing settings, with
// random gaps on both channels; the checker predicts and compares results.
//------------------------------------------------------------------------------
module tb_top;
    import i2cm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // operation, device_address, register_index, byte_count, tx_byte,
    // tx_valid, scl_in, sda_in; zero fill to 48 bits
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // scl_pull_low, sda_pull_low, tx_request, rx_byte, rx_valid, busy_res,
    // done_res, status; zero fill to 24 bits
    logic [23:0] m_axis_tdata;
    // rx_last
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int   fail_count;
    int   pending;
    logic last_busy;
    int   txn_count;
    int   rx_count;
    int   sender_idle_pct = 9;
    int   receiver_idle_pct = 52;
    int   tick_total = 0;
    int   scl_low_run = 0;

    i2c_master_transaction_engine_unit DUT (.*);

    i2cm_checker u_checker (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending), .o_last_busy(last_busy),
        .o_txn_count(txn_count), .o_rx_count(rx_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The receiver stalls at random.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // Hand one tick to the engine; tready is taken from the low clock phase.
    task automatic send_tick(t_tick t);
        logic ready_seen;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, t.sda_in, t.scl_in, t.tx_valid, t.tx_byte, t.byte_count,
                          t.register_index, t.device_address, t.operation};
        do begin
            @(negedge i_clk);
            ready_seen = s_axis_tready;
            @(posedge i_clk);
        end while (!ready_seen);
        tick_total++;
    endtask

    // Random tick: mostly acknowledged bits on a free clock line, with
    // occasional stretching bursts and new commands, and random payload offers.
    task automatic random_tick(output t_tick t);
        logic [2:0] op;
        t = '0;
        if ($urandom_range(0, 29) == 0) begin
            op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(1, 4));
            if ($urandom_range(0, 19) == 0) op = OP_NONE;
            t.operation      = op;
            t.device_address = 7'($urandom);
            t.register_index = 8'($urandom);
            t.byte_count     = 16'($urandom_range(0, 3));
            if ((op == OP_WRITE || op == OP_REG_WR) && $urandom_range(0, 9) == 0)
                t.byte_count = 16'($urandom);
        end
        if (scl_low_run == 0 && $urandom_range(0, 39) == 0)
            scl_low_run = $urandom_range(1, 8);
        t.scl_in = (scl_low_run == 0);
        if (scl_low_run > 0) scl_low_run--;
        t.sda_in   = ($urandom_range(0, 99) < 20);
        t.tx_valid = 1'($urandom_range(0, 1));
        t.tx_byte  = 8'($urandom);
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Feed plain ticks until every result is in and the engine reports idle.
    task automatic drain_engine();
        t_tick t;
        forever begin
            repeat (16) begin
                t          = '0;
                t.scl_in   = 1'b1;
                t.sda_in   = 1'($urandom_range(0, 1));
                t.tx_valid = 1'b1;
                t.tx_byte  = 8'($urandom);
                send_tick(t);
            end
            s_axis_tvalid <= 1'b0;
            wait (pending == 0);
            repeat (8) @(posedge i_clk);
            if (!last_busy) break;
        end
    endtask

    task automatic directed_command(logic [2:0] op, logic [6:0] addr, logic [7:0] reg_idx,
                                    logic [15:0] count);
        t_tick t;
        t                = '0;
        t.operation      = op;
        t.device_address = addr;
        t.register_index = reg_idx;
        t.byte_count     = count;
        t.scl_in         = 1'b1;
        send_tick(t);
        // A command while busy must be ignored.
        t.operation = OP_READ;
        send_tick(t);
        drain_engine();
    endtask

    initial begin
        int    phase_ticks[5];
        int    half_set[5];
        int    stretch_set[5];
        int    wait_set[5];
        t_tick t;
        phase_ticks = '{150, 150, 200, 150, 150};
        half_set    = '{1, 2, 0, 4, 3};
        stretch_set = '{0, 3, 65535, 65535, 1000};
        wait_set    = '{0, 5, 65535, 0, 30000};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed commands: every operation, address and register extremes,
        // zero counts, the longest count and the unknown codes.
        write_register(REG_HALF, 32'd1);
        directed_command(OP_WRITE, 7'd0, 8'd0, 16'd0);
        directed_command(OP_WRITE, 7'd127, 8'd255, 16'd2);
        directed_command(OP_READ, 7'h55, 8'h00, 16'd0);
        directed_command(OP_READ, 7'h2A, 8'hFF, 16'd2);
        directed_command(OP_REG_WR, 7'h50, 8'hA5, 16'd1);
        directed_command(OP_REG_WR, 7'h0F, 8'h5A, 16'd0);
        directed_command(OP_REG_RD, 7'h70, 8'h5A, 16'd3);
        directed_command(OP_WRITE, 7'h33, 8'h00, 16'hFFFF);
        directed_command(3'd5, 7'h11, 8'h22, 16'd1);
        directed_command(3'd6, 7'h11, 8'h22, 16'd1);
        directed_command(3'd7, 7'h11, 8'h22, 16'd1);

        // Random phases under several timing settings and idling patterns.
        for (int p = 0; p < 5; p++) begin
            sender_idle_pct   = (p == 0) ? 9 : (p == 1) ? 52 : 0;
            receiver_idle_pct = (p == 0) ? 52 : (p == 1) ? 9 : 0;
            write_register(REG_HALF, half_set[p]);
            write_register(REG_STRETCH, stretch_set[p]);
            write_register(REG_BUSWAIT, wait_set[p]);
            repeat (phase_ticks[p]) begin
                random_tick(t);
                send_tick(t);
            end
            drain_engine();
        end

        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d ticks over five timing settings; %0d transactions ended, %0d bytes read.",
                 tick_total, txn_count, rx_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Guard against a hung run.
    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
